### hw/rtl/fptp_pkg.sv
`default_nettype none

package fptp_pkg;

    // field widths of the transaction payloads
    localparam int PRIO_W = 5;
    localparam int TID_W  = 16;
    localparam int SLOT_W = 6;
    localparam int SEC_W  = 6;
    localparam int TIE_W  = 7;

    // transaction modes
    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_SCHED = 1'b1;

    // remainder unit step counter, one dividend bit per step
    localparam int DIV_STEP_W = 3;

    // priority limit after reset
    localparam logic [PRIO_W-1:0] LIMIT_RESET = 5'd20;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DIV_START,
        S_DIV_WAIT,
        S_PICK,
        S_TID,
        S_FINISH
    } state_t;

    // request into the remainder unit
    typedef struct packed {
        logic             start;
        logic [SEC_W-1:0] dividend;
    } div_req_t;

    // status back from the remainder unit
    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

`default_nettype wire

### hw/rtl/fptp_mod_unit.sv
`default_nettype none

module fptp_mod_unit #(
    parameter int CNT_W = 7
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire fptp_pkg::div_req_t   req,
    input  wire logic [CNT_W-1:0]     divisor,
    output fptp_pkg::div_status_t     status,
    output logic [CNT_W-1:0]          remainder
);

    logic [CNT_W-1:0]                       rem_reg, rem_next;
    logic [fptp_pkg::SEC_W-1:0]             quo_reg, quo_next;
    logic [fptp_pkg::DIV_STEP_W-1:0]        step_reg, step_next;
    logic                                   busy_reg, busy_next;
    logic                                   done_reg, done_next;
    logic [CNT_W:0]                         shifted;
    logic [CNT_W:0]                         diff;
    logic                                   fits;

    // one restoring step: bring in the next dividend bit, subtract if it fits
    always_comb
    begin
        shifted   = {rem_reg, quo_reg[fptp_pkg::SEC_W-1]};
        diff      = shifted - {1'b0, divisor};
        fits      = (shifted >= {1'b0, divisor});
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            rem_next  = '0;
            quo_next  = req.dividend;
            step_next = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next  = fits ? diff[CNT_W-1:0] : shifted[CNT_W-1:0];
            quo_next  = {quo_reg[fptp_pkg::SEC_W-2:0], 1'b0};
            step_next = step_reg + fptp_pkg::DIV_STEP_W'(1);
            if (step_reg == fptp_pkg::DIV_STEP_W'(fptp_pkg::SEC_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // partial remainder and dividend shifter
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign remainder   = rem_reg;

`ifndef NO_ASSERTIONS
    // finished remainder is always below the divisor
    assert property (@(posedge clk) disable iff (!rst_n) done_reg |-> (rem_reg < divisor))
        else $error("remainder not below divisor");

    // a new request only arrives while the unit is free
    assert property (@(posedge clk) disable iff (!rst_n) req.start |-> !busy_reg)
        else $error("remainder unit restarted while busy");

    // done is a single pulse after the last step
    assert property (@(posedge clk) disable iff (!rst_n) done_reg |=> !done_reg && !busy_reg)
        else $error("remainder unit done pulse malformed");
`endif

endmodule

`default_nettype wire

### hw/rtl/fixed_priority_random_tiebreak_picker.sv
// Fixed-priority task picker with a seconds-based tie-break. A write transaction
// (mode 0) stores one slot and gives an all-zero result. A schedule transaction
// (mode 1) proceeds in order: one pass over the slot table finds the lowest eligible
// priority and the number of slots that share it, a six-step remainder unit
// forms the tie-break index, and a second pass finds that slot and clears its
// runnable flag. Both passes go through one priority comparator and one read
// port of the priority memory, one slot per cycle. in_ready is high only
// between transactions; a finished result waits in the output register while
// the next transaction is taken. Priorities and task ids live in memories with
// no reset; runnable flags are flip-flops cleared by reset, so no clearing pass
// is needed. priority_limit may be written only while the block is idle.
`default_nettype none

module fixed_priority_random_tiebreak_picker #(
    parameter int NUM_SLOTS = 64
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    output logic                                    in_ready,
    input  wire logic                               mode,
    input  wire logic [fptp_pkg::SLOT_W-1:0]        slot_index,
    input  wire logic                               runnable_in,
    input  wire logic [fptp_pkg::PRIO_W-1:0]        priority_in,
    input  wire logic [fptp_pkg::TID_W-1:0]         task_id_in,
    input  wire logic [fptp_pkg::SEC_W-1:0]         tick_seconds,
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output logic                                    found,
    output logic [fptp_pkg::SLOT_W-1:0]             chosen_slot,
    output logic [fptp_pkg::TID_W-1:0]              chosen_task_id,
    output logic [fptp_pkg::TIE_W-1:0]              tie_count,
    input  wire logic                               cfg_wr_en,
    input  wire logic [fptp_pkg::PRIO_W-1:0]        cfg_wr_data
);

    localparam int IDX_W = $clog2(NUM_SLOTS);
    localparam int CNT_W = $clog2(NUM_SLOTS + 1);

    fptp_pkg::state_t                   state_reg, state_next;
    logic [fptp_pkg::PRIO_W-1:0]        limit_reg;
    logic [NUM_SLOTS-1:0]               runnable_reg;
    logic [fptp_pkg::PRIO_W-1:0]        prio_mem [NUM_SLOTS];
    logic [fptp_pkg::TID_W-1:0]         tid_mem [NUM_SLOTS];

    logic [fptp_pkg::PRIO_W-1:0]        prio_rd_reg;
    logic                               run_rd_reg;
    logic                               rd_en_reg;
    logic [IDX_W-1:0]                   rd_idx_reg;
    logic [fptp_pkg::TID_W-1:0]         tid_rd_reg;

    logic [CNT_W-1:0]                   scan_cnt_reg, scan_cnt_next;
    logic [fptp_pkg::PRIO_W-1:0]        best_reg, best_next;
    logic [CNT_W-1:0]                   count_reg, count_next;
    logic [CNT_W-1:0]                   k_reg, k_next;
    logic [CNT_W-1:0]                   seen_reg, seen_next;
    logic [fptp_pkg::SEC_W-1:0]         secs_reg, secs_next;
    logic [IDX_W-1:0]                   chosen_reg, chosen_next;
    logic                               res_found_reg, res_found_next;

    logic                               out_valid_reg;
    logic                               out_found_reg;
    logic [fptp_pkg::SLOT_W-1:0]        out_slot_reg;
    logic [fptp_pkg::TID_W-1:0]         out_tid_reg;
    logic [fptp_pkg::TIE_W-1:0]         out_tie_reg;

    logic [IDX_W-1:0]                   scan_addr;
    logic [IDX_W-1:0]                   wr_addr;
    logic                               wr_in_range;
    logic                               mem_wr_en;
    logic                               issue;
    logic                               scan_done;
    logic                               clear_en;
    logic                               out_load;
    logic                               lower;
    logic                               match;
    logic                               pick_hit;

    fptp_pkg::div_req_t                 div_req;
    fptp_pkg::div_status_t              div_status;
    logic [CNT_W-1:0]                   div_rem;

    // addresses into the slot table
    assign scan_addr   = scan_cnt_reg[IDX_W-1:0];
    assign wr_addr     = IDX_W'(32'(slot_index));
    assign wr_in_range = (32'(slot_index) < NUM_SLOTS);
    assign scan_done   = (scan_cnt_reg == CNT_W'(NUM_SLOTS));

    // shared priority comparator
    assign lower    = rd_en_reg && run_rd_reg && (prio_rd_reg < best_reg);
    assign match    = rd_en_reg && run_rd_reg && (prio_rd_reg == best_reg);
    assign pick_hit = (state_reg == fptp_pkg::S_PICK) && match && (seen_reg == k_reg);

    // sequencer outputs
    always_comb
    begin
        in_ready         = (state_reg == fptp_pkg::S_IDLE);
        issue            = ((state_reg == fptp_pkg::S_SCAN) ||
                            (state_reg == fptp_pkg::S_PICK)) && !scan_done;
        mem_wr_en        = (state_reg == fptp_pkg::S_IDLE) && in_valid &&
                           (mode == fptp_pkg::MODE_WRITE) && wr_in_range;
        div_req.start    = (state_reg == fptp_pkg::S_DIV_START) && (count_reg != '0);
        div_req.dividend = secs_reg;
        clear_en         = (state_reg == fptp_pkg::S_TID);
        out_load         = (state_reg == fptp_pkg::S_FINISH) &&
                           (!out_valid_reg || out_ready);
    end

    // sequencer next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            fptp_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = (mode == fptp_pkg::MODE_SCHED) ? fptp_pkg::S_SCAN
                                                                : fptp_pkg::S_FINISH;
                end
            end
            fptp_pkg::S_SCAN:
            begin
                if (scan_done)
                begin
                    state_next = fptp_pkg::S_DIV_START;
                end
            end
            fptp_pkg::S_DIV_START:
            begin
                state_next = (count_reg == '0) ? fptp_pkg::S_FINISH : fptp_pkg::S_DIV_WAIT;
            end
            fptp_pkg::S_DIV_WAIT:
            begin
                if (div_status.done)
                begin
                    state_next = fptp_pkg::S_PICK;
                end
            end
            fptp_pkg::S_PICK:
            begin
                if (pick_hit)
                begin
                    state_next = fptp_pkg::S_TID;
                end
                else if (scan_done)
                begin
                    state_next = fptp_pkg::S_FINISH;
                end
            end
            fptp_pkg::S_TID:
            begin
                state_next = fptp_pkg::S_FINISH;
            end
            fptp_pkg::S_FINISH:
            begin
                if (out_load)
                begin
                    state_next = fptp_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = fptp_pkg::S_IDLE;
            end
        endcase
    end

    // working registers of the scan, remainder and pick steps
    always_comb
    begin
        scan_cnt_next  = scan_cnt_reg;
        best_next      = best_reg;
        count_next     = count_reg;
        k_next         = k_reg;
        seen_next      = seen_reg;
        secs_next      = secs_reg;
        chosen_next    = chosen_reg;
        res_found_next = res_found_reg;
        case (state_reg)
            fptp_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    secs_next      = tick_seconds;
                    best_next      = limit_reg;
                    count_next     = '0;
                    scan_cnt_next  = '0;
                    res_found_next = 1'b0;
                end
            end
            fptp_pkg::S_SCAN:
            begin
                if (issue)
                begin
                    scan_cnt_next = scan_cnt_reg + CNT_W'(1);
                end
                // new minimum restarts the tie count
                if (lower)
                begin
                    best_next  = prio_rd_reg;
                    count_next = CNT_W'(1);
                end
                else if (match)
                begin
                    count_next = count_reg + CNT_W'(1);
                end
            end
            fptp_pkg::S_DIV_START:
            begin
                scan_cnt_next = '0;
                seen_next     = '0;
            end
            fptp_pkg::S_DIV_WAIT:
            begin
                if (div_status.done)
                begin
                    k_next = div_rem;
                end
            end
            fptp_pkg::S_PICK:
            begin
                if (issue)
                begin
                    scan_cnt_next = scan_cnt_reg + CNT_W'(1);
                end
                if (pick_hit)
                begin
                    chosen_next    = rd_idx_reg;
                    res_found_next = 1'b1;
                end
                else if (match)
                begin
                    seen_next = seen_reg + CNT_W'(1);
                end
            end
            default:
            begin
            end
        endcase
    end

    // tie-break remainder unit
    fptp_mod_unit #(
        .CNT_W (CNT_W)
    ) u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (div_req),
        .divisor   (count_reg),
        .status    (div_status),
        .remainder (div_rem)
    );

    // control registers and runnable flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= fptp_pkg::S_IDLE;
            limit_reg     <= fptp_pkg::LIMIT_RESET;
            runnable_reg  <= '0;
            rd_en_reg     <= 1'b0;
            scan_cnt_reg  <= '0;
            res_found_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rd_en_reg     <= issue;
            scan_cnt_reg  <= scan_cnt_next;
            res_found_reg <= res_found_next;
            if (cfg_wr_en)
            begin
                limit_reg <= cfg_wr_data;
            end
            if (mem_wr_en)
            begin
                runnable_reg[wr_addr] <= runnable_in;
            end
            else if (clear_en)
            begin
                runnable_reg[chosen_reg] <= 1'b0;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // slot memories: one write port, registered reads
    always_ff @(posedge clk)
    begin
        if (mem_wr_en)
        begin
            prio_mem[wr_addr] <= priority_in;
            tid_mem[wr_addr]  <= task_id_in;
        end
        prio_rd_reg <= prio_mem[scan_addr];
        tid_rd_reg  <= tid_mem[chosen_reg];
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        run_rd_reg <= runnable_reg[scan_addr];
        rd_idx_reg <= scan_addr;
        best_reg   <= best_next;
        count_reg  <= count_next;
        k_reg      <= k_next;
        seen_reg   <= seen_next;
        secs_reg   <= secs_next;
        chosen_reg <= chosen_next;
        if (out_load)
        begin
            out_found_reg <= res_found_reg;
            out_slot_reg  <= res_found_reg ? fptp_pkg::SLOT_W'(32'(chosen_reg)) : '0;
            out_tid_reg   <= res_found_reg ? tid_rd_reg : '0;
            out_tie_reg   <= res_found_reg ? fptp_pkg::TIE_W'(32'(count_reg)) : '0;
        end
    end

    assign out_valid      = out_valid_reg;
    assign found          = out_found_reg;
    assign chosen_slot    = out_slot_reg;
    assign chosen_task_id = out_tid_reg;
    assign tie_count      = out_tie_reg;

`ifndef NO_ASSERTIONS
    // tie count never exceeds the table size
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == fptp_pkg::S_DIV_START) |-> (count_reg <= CNT_W'(NUM_SLOTS)))
        else $error("tie count beyond table size");

    // tie-break index stays inside the tie group while picking
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == fptp_pkg::S_PICK) |-> (k_reg < count_reg))
        else $error("tie-break index outside tie group");

    // the picked slot is runnable when chosen
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == fptp_pkg::S_TID) |-> runnable_reg[chosen_reg])
        else $error("picked slot not runnable");

    // the picked slot is no longer runnable afterwards
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == fptp_pkg::S_TID) |=> !runnable_reg[$past(chosen_reg)])
        else $error("picked slot still runnable");
`endif

endmodule

`default_nettype wire
